/* rtl/sgbr_pkg.sv */
// Shared constants for the stem gain band ratio block.
// Used by sgbr_mix, sgbr_sqrt_lane and the top level.
package sgbr_pkg;
	localparam int NUM_GAINS   = 4;
	localparam int FIELD_BANDS = 3;
	localparam int LANES       = FIELD_BANDS + 1;
	localparam int FIELD_W     = 24;
	localparam int GAIN_W      = 17;
	localparam int GSQ_W       = 2 * GAIN_W;
	localparam int RATIO_W     = 16;
	localparam int IN_W        = NUM_GAINS * FIELD_BANDS * FIELD_W;
	localparam int OUT_W       = LANES * RATIO_W;
	localparam int IDX_W       = 3;
	localparam int MIX_STAGES  = 3;
	localparam int SQRT_STAGES = RATIO_W;
	localparam int SUM_GROW    = 4;

	localparam int STEMS_DEF      = 4;
	localparam int BANDS_DEF      = 3;
	localparam int POWER_BITS_DEF = 24;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 17'd65536;
	localparam logic [RATIO_W-1:0] UNITY_Q14  = 16'd16384;

	localparam logic [IDX_W-1:0] REG_GAIN_STEM0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_STEM1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_STEM2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_STEM3 = 3'd3;
endpackage

/* rtl/sgbr_mix.sv */
// Gain weighting and band / broadband power sums, three pipeline stages.
// Depends on sgbr_pkg.
module sgbr_mix #(
	parameter int STEMS = 4,
	parameter int BANDS = 3,
	parameter int PW    = 24,
	parameter int MW    = 62,
	parameter int UW    = 28
) (
	input  logic                     clk,
	input  logic [2:0]               en,
	input  logic [sgbr_pkg::IN_W-1:0] pow,
	input  logic [sgbr_pkg::GSQ_W-1:0] gsq [sgbr_pkg::NUM_GAINS],
	output logic [MW-1:0]            moved [sgbr_pkg::LANES],
	output logic [UW-1:0]            unity [sgbr_pkg::LANES]
);
	import sgbr_pkg::*;

	localparam int PROD_W = GSQ_W + PW;

	logic [PW-1:0]     pm [NUM_GAINS][FIELD_BANDS];
	logic [PW-1:0]     p_s1 [NUM_GAINS][FIELD_BANDS];
	logic [PROD_W-1:0] prod_s1 [NUM_GAINS][FIELD_BANDS];
	logic [MW-1:0]     mb;
	logic [UW-1:0]     ub;
	logic [MW-1:0]     moved_s2 [FIELD_BANDS];
	logic [UW-1:0]     unity_s2 [FIELD_BANDS];
	logic [MW-1:0]     moved_s3 [LANES];
	logic [UW-1:0]     unity_s3 [LANES];

	always_comb begin
		for (int s = 0; s < NUM_GAINS; s++) begin
			for (int b = 0; b < FIELD_BANDS; b++) begin
				if (s < STEMS && b < BANDS) begin
					pm[s][b] = pow[(s*FIELD_BANDS+b)*FIELD_W +: PW];
				end else begin
					pm[s][b] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int s = 0; s < NUM_GAINS; s++) begin
				for (int b = 0; b < FIELD_BANDS; b++) begin
					p_s1[s][b]    <= pm[s][b];
					prod_s1[s][b] <= PROD_W'(gsq[s]) * PROD_W'(pm[s][b]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int b = 0; b < FIELD_BANDS; b++) begin
				moved_s2[b] <= MW'(prod_s1[0][b]) + MW'(prod_s1[1][b])
					+ MW'(prod_s1[2][b]) + MW'(prod_s1[3][b]);
				unity_s2[b] <= UW'(p_s1[0][b]) + UW'(p_s1[1][b])
					+ UW'(p_s1[2][b]) + UW'(p_s1[3][b]);
			end
		end
	end

	assign mb = moved_s2[0] + moved_s2[1] + moved_s2[2];
	assign ub = unity_s2[0] + unity_s2[1] + unity_s2[2];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int b = 0; b < FIELD_BANDS; b++) begin
				moved_s3[b] <= moved_s2[b];
				unity_s3[b] <= unity_s2[b];
			end
			moved_s3[FIELD_BANDS] <= mb;
			unity_s3[FIELD_BANDS] <= ub;
		end
	end

	assign moved = moved_s3;
	assign unity = unity_s3;
endmodule

/* rtl/sgbr_sqrt_lane.sv */
// One ratio lane: floor(sqrt(moved / (16 * unity))), one result bit per stage.
// Depends on sgbr_pkg.
module sgbr_sqrt_lane #(
	parameter int MW = 62,
	parameter int UW = 28
) (
	input  logic                            clk,
	input  logic [sgbr_pkg::SQRT_STAGES-1:0] en,
	input  logic [MW-1:0]                   moved,
	input  logic [UW-1:0]                   unity,
	output logic [sgbr_pkg::RATIO_W-1:0]    ratio
);
	import sgbr_pkg::*;

	localparam int CW = ((MW > UW + 4 + 2*RATIO_W) ? MW : UW + 4 + 2*RATIO_W) + 2;

	logic [CW-1:0]      a_q [SQRT_STAGES];
	logic [CW-1:0]      b_q [SQRT_STAGES];
	logic [RATIO_W-1:0] r_q [SQRT_STAGES];
	logic [MW-1:0]      m_q [SQRT_STAGES];
	logic [UW-1:0]      u_q [SQRT_STAGES];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		localparam int K = SQRT_STAGES - 1 - j;
		logic [CW-1:0]      a_in, b_in, u16, cand;
		logic [RATIO_W-1:0] r_in;
		logic [MW-1:0]      m_in;
		logic [UW-1:0]      u_in;
		logic               ok;

		if (j == 0) begin : g_first
			assign a_in = '0;
			assign b_in = '0;
			assign r_in = '0;
			assign m_in = moved;
			assign u_in = unity;
		end else begin : g_next
			assign a_in = a_q[j-1];
			assign b_in = b_q[j-1];
			assign r_in = r_q[j-1];
			assign m_in = m_q[j-1];
			assign u_in = u_q[j-1];
		end

		assign u16  = CW'(u_in) << 4;
		assign cand = a_in + (b_in << (K + 1)) + (u16 << (2 * K));
		assign ok   = cand <= CW'(m_in);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				a_q[j] <= ok ? cand : a_in;
				b_q[j] <= ok ? b_in + (u16 << K) : b_in;
				r_q[j] <= ok ? (r_in | (RATIO_W'(1) << K)) : r_in;
				m_q[j] <= m_in;
				u_q[j] <= u_in;
			end
		end
	end

	assign ratio = (u_q[SQRT_STAGES-1] == '0) ? UNITY_Q14 : r_q[SQRT_STAGES-1];
endmodule

/* rtl/stem_gain_band_ratio.sv */
// Stem gain band ratio: per-column amplitude ratio of a gain-weighted stem mix.
// Input channel s_*: one column per transfer, twelve 24-bit powers.
// Output channel m_*: four Q2.14 ratios (three bands and broadband).
// Config port: cfg_we / cfg_index / cfg_data write the four stem gains (Q1.16);
// the squared gain is registered at the write. Write only while idle.
// Pipeline: 19 registers (3 mix stages, 16 root stages of one result bit each,
// four lanes side by side).
// Throughput: one column per cycle; every stage holds its own valid bit, so
// a stalled receiver only stops the stages behind a full one and bubbles are
// filled. s_tready drops only when all 19 stages hold data and m_tready is low.
// A band with no power gives 16384 (1.0).
// Reset: empties the pipeline and sets every gain to unity; m_tvalid is low.
// Depends on sgbr_pkg, sgbr_mix, sgbr_sqrt_lane.
module stem_gain_band_ratio #(
	parameter int STEMS      = sgbr_pkg::STEMS_DEF,
	parameter int BANDS      = sgbr_pkg::BANDS_DEF,
	parameter int POWER_BITS = sgbr_pkg::POWER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pow_s0_b0, pow_s0_b1, pow_s0_b2, pow_s1_b0 .. pow_s3_b2, 24 bits each
	input  logic [sgbr_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// ratio_band0, ratio_band1, ratio_band2, ratio_broad, 16 bits each
	output logic [sgbr_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic [sgbr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sgbr_pkg::GAIN_W-1:0]  cfg_data
);
	import sgbr_pkg::*;

	localparam int PW = (POWER_BITS < FIELD_W) ? POWER_BITS : FIELD_W;
	localparam int MW = GSQ_W + PW + SUM_GROW;
	localparam int UW = PW + SUM_GROW;
	localparam int N  = MIX_STAGES + SQRT_STAGES;

	localparam logic [IDX_W-1:0] REG_IDX [NUM_GAINS] =
		'{REG_GAIN_STEM0, REG_GAIN_STEM1, REG_GAIN_STEM2, REG_GAIN_STEM3};

	logic [GSQ_W-1:0] gsq_q [NUM_GAINS];
	logic [N-1:0]     v_q;
	logic [N:0]       rdy;
	logic [MW-1:0]    moved [LANES];
	logic [UW-1:0]    unity [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAINS; i++) begin
				gsq_q[i] <= GSQ_W'(GAIN_RESET) * GSQ_W'(GAIN_RESET);
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_GAINS; i++) begin
				if (cfg_index == REG_IDX[i]) begin
					gsq_q[i] <= GSQ_W'(cfg_data) * GSQ_W'(cfg_data);
				end
			end
		end
	end

	always_comb begin
		rdy[N] = m_tready;
		for (int i = N - 1; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (rdy[i]) begin
					v_q[i] <= (i == 0) ? s_tvalid : v_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = v_q[N-1];

	sgbr_mix #(
		.STEMS(STEMS), .BANDS(BANDS), .PW(PW), .MW(MW), .UW(UW)
	) u_mix (
		.clk(clk), .en(rdy[MIX_STAGES-1:0]), .pow(s_tdata), .gsq(gsq_q),
		.moved(moved), .unity(unity)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		sgbr_sqrt_lane #(.MW(MW), .UW(UW)) u_lane (
			.clk(clk), .en(rdy[N-1:MIX_STAGES]), .moved(moved[l]), .unity(unity[l]),
			.ratio(m_tdata[l*RATIO_W +: RATIO_W])
		);
	end
endmodule

/* rtl/sgbr_check.sv */
// Port-level checks for stem_gain_band_ratio, attached by bind.
// Depends on sgbr_pkg.
module sgbr_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [sgbr_pkg::OUT_W-1:0]   m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output side can move");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");
endmodule

bind stem_gain_band_ratio sgbr_check u_sgbr_check (.*);

/* dv/stem_gain_band_ratio_test.sv */
// Testbench for stem_gain_band_ratio: random and directed power columns with
// backpressure, checked against an in-bench fixed-point predictor.
// Depends on sgbr_pkg and the RTL top level only.

class ratio_scoreboard;
	logic [16:0] gain [sgbr_pkg::NUM_GAINS];
	logic [sgbr_pkg::OUT_W-1:0] ratio_q [$];
	int errors;

	function new();
		foreach (gain[s]) gain[s] = sgbr_pkg::GAIN_RESET;
		errors = 0;
	endfunction

	function void set_gain(int idx, logic [16:0] value);
		if (idx < sgbr_pkg::NUM_GAINS)
			gain[idx] = value;
	endfunction

	// floor(sqrt(moved / (16 * unity))) in Q2.14, saturated
	static function logic [15:0] root_q14(logic [127:0] moved, logic [127:0] unity);
		logic [15:0] r;
		logic [127:0] t;
		if (unity == 0)
			return sgbr_pkg::UNITY_Q14;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = {112'd0, r | (16'd1 << b)};
			if (t * t * 16 * unity <= moved)
				r = r | (16'd1 << b);
		end
		return r;
	endfunction

	function void note_column(logic [sgbr_pkg::IN_W-1:0] col);
		logic [127:0] moved, unity, wsum_tot, psum_tot, p, g;
		logic [sgbr_pkg::OUT_W-1:0] res;
		wsum_tot = '0;
		psum_tot = '0;
		for (int b = 0; b < 3; b++) begin
			moved = '0;
			unity = '0;
			for (int s = 0; s < 4; s++) begin
				p = 128'(col[(s*3+b)*24 +: 24]);
				g = 128'(gain[s]);
				unity += p;
				moved += g * g * p;
			end
			res[b*16 +: 16] = root_q14(moved, unity);
			wsum_tot += moved;
			psum_tot += unity;
		end
		res[48 +: 16] = root_q14(wsum_tot, psum_tot);
		ratio_q.push_back(res);
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_ratio(logic [sgbr_pkg::OUT_W-1:0] got);
		logic [sgbr_pkg::OUT_W-1:0] want;
		if (ratio_q.size() == 0) begin
			report($sformatf("unexpected result %h", got));
			return;
		end
		want = ratio_q.pop_front();
		for (int f = 0; f < 4; f++)
			if (got[f*16 +: 16] !== want[f*16 +: 16])
				report($sformatf("field %0d got %0d want %0d", f,
					got[f*16 +: 16], want[f*16 +: 16]));
	endtask
endclass

module stem_gain_band_ratio_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sgbr_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	int send_idle = 0, recv_idle = 0, hold_len = 0, hold_cnt = 0;
	ratio_scoreboard sb = new();

	stem_gain_band_ratio uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_ratio(m_tdata);
	end

	always @(negedge clk) begin
		if (hold_cnt < hold_len) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task write_gain(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_gain(idx, value);
		@(negedge clk);
	endtask

	task send_column(logic [IN_W-1:0] col);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= col;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_column(col);
		@(negedge clk);
	endtask

	task drain;
		s_tvalid <= 0;
		while (sb.ratio_q.size() != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	function automatic logic [23:0] rand_power();
		case ($urandom_range(5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(255));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rand_column();
		logic [IN_W-1:0] col;
		for (int i = 0; i < 12; i++) begin
			col[i*24 +: 24] = rand_power();
			if ($urandom_range(7) == 0)
				for (int s = 0; s < 4; s++) col[(s*3 + i%3)*24 +: 24] = '0;
		end
		return col;
	endfunction

	function automatic logic [16:0] rand_gain();
		case ($urandom_range(4))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			default: return 17'($urandom_range(131071));
		endcase
	endfunction

	task random_phase(int count, int s_idle, int r_idle);
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < count; i++)
			send_column(rand_column());
		drain();
	endtask

	initial begin
		#1000000;
		$display("** stem_gain_band_ratio: FAILED **");
		$finish;
	end

	initial begin
		logic [IN_W-1:0] col;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_column('0);
		send_column({IN_W{1'b1}});
		for (int i = 0; i < 12; i++) begin
			col = '0;
			col[i*24 +: 24] = 24'hFFFFFF;
			send_column(col);
		end
		drain();
		write_gain(REG_GAIN_STEM0, 17'd0);
		write_gain(REG_GAIN_STEM1, 17'h1FFFF);
		write_gain(REG_GAIN_STEM2, 17'd1);
		write_gain(REG_GAIN_STEM3, 17'd65535);
		write_gain(3'd5, 17'd77);
		send_column({IN_W{1'b1}});
		for (int s = 0; s < 4; s++) begin
			col = '0;
			for (int b = 0; b < 3; b++) col[(s*3+b)*24 +: 24] = 24'hFFFFFF;
			send_column(col);
		end
		send_column('0);
		for (int i = 0; i < 5; i++) send_column(rand_column());
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int g = 0; g < 4; g++)
				write_gain(g[IDX_W-1:0], rand_gain());
			case (ph % 3)
				0: random_phase(250, 28, 62);
				1: random_phase(250, 62, 28);
				default: random_phase(250, 0, 0);
			endcase
		end

		hold_len = 60;
		send_idle = 0;
		for (int i = 0; i < 40; i++) send_column(rand_column());
		drain();

		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("** stem_gain_band_ratio: PASSED **");
		else
			$display("** stem_gain_band_ratio: FAILED **");
		$finish;
	end
endmodule

/* filelist.f */
rtl/sgbr_pkg.sv
rtl/sgbr_mix.sv
rtl/sgbr_sqrt_lane.sv
rtl/stem_gain_band_ratio.sv
rtl/sgbr_check.sv
dv/stem_gain_band_ratio_test.sv
